// ===== sv/fkp_pkg.sv =====
// fkp_pkg: shared types and constants of the four-key front panel controller
// no dependencies; imported by every module of the block
`default_nettype none

package fkp_pkg;

    // width of the per-key hold timers in milliseconds (12 to 32)
    localparam int COUNT_WIDTH = 16;

    // event queue between the key front and the settings back
    localparam int EVQ_DEPTH = 4;

    // configuration register widths
    localparam int TICK_W  = 7;
    localparam int TIME_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam int OPT_W   = 2;
    localparam int HOLD_W  = 11;

    // menu options
    localparam logic [OPT_W-1:0] OPT_NONE  = 2'd0;
    localparam logic [OPT_W-1:0] OPT_LEVEL = 2'd1;
    localparam logic [OPT_W-1:0] OPT_TIME  = 2'd2;
    localparam logic [OPT_W-1:0] OPT_WRAP  = 2'd3;

    // configuration values seen by the front and back parts
    typedef struct packed {
        logic [TICK_W-1:0] tick_ms;
        logic [TIME_W-1:0] time_limit;
    } fkp_cfg_t;

    // key actions found by the front for one scan beat
    typedef struct packed {
        logic start_click;
        logic menu_click;
        logic minus_act;
        logic minus_big;
        logic plus_act;
        logic plus_big;
        logic long_beep;
    } fkp_evt_t;

    // one result beat
    typedef struct packed {
        logic              run_state;
        logic [OPT_W-1:0]  menu_option;
        logic              level_setting;
        logic [TIME_W-1:0] time_setting;
        logic              reload_remaining;
        logic              beep_short;
        logic              beep_double;
        logic              settings_done;
        logic              blink_start;
        logic              hold_active;
    } fkp_res_t;

endpackage

`default_nettype wire

// ===== sv/four_key_front_panel_controller.sv =====
// four_key_front_panel_controller: top level of the front panel key controller
// depends on fkp_pkg, fkp_front, fkp_evq, fkp_back
`default_nettype none

// Takes one scan beat per clock while not full (push/full), carrying the
// decoded key of that tick, and returns one result beat per scan beat
// (empty/pop) with the current settings and one-tick event pulses. The front
// part keeps a millisecond hold timer per key and classifies each beat into
// clicks, repeats and long holds; a four-entry event queue hands those to the
// back part, which owns run state, menu option, level, time setting and the
// no-blink hold countdown and writes each finished result into a two-entry
// result queue. Throughput is one beat per clock while no queue is full,
// as the back part updates its settings registers on each event it pops; the
// event is held in the event queue, then its result in the result queue.
// tick_ms and time_limit are written through cfg_we/cfg_idx/cfg_data and
// should only change while no beat is in flight.
module four_key_front_panel_controller (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration writes
    input  wire logic                        cfg_we,
    input  wire logic [fkp_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [fkp_pkg::CFG_W-1:0]   cfg_data,
    // scan beats in
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [2:0]                  key_code,
    // result beats out
    output logic                             empty,
    input  wire logic                        pop,
    output logic                             run_state,
    output logic [fkp_pkg::OPT_W-1:0]        menu_option,
    output logic                             level_setting,
    output logic [fkp_pkg::TIME_W-1:0]       time_setting,
    output logic                             reload_remaining,
    output logic                             beep_short,
    output logic                             beep_double,
    output logic                             settings_done,
    output logic                             blink_start,
    output logic                             hold_active
);
    import fkp_pkg::*;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT = 1'd1;

    localparam logic [TICK_W-1:0] TICK_MS_RESET    = TICK_W'(10);
    localparam logic [TIME_W-1:0] TIME_LIMIT_RESET = TIME_W'(7200);

    logic [TICK_W-1:0] tick_ms_reg;
    logic [TIME_W-1:0] time_limit_reg;
    fkp_cfg_t          cfg;

    logic      in_take;
    fkp_evt_t  front_evt;
    fkp_evt_t  q_evt;
    logic      q_empty;
    logic      q_pop;
    fkp_res_t  res;

    assign cfg.tick_ms    = tick_ms_reg;
    assign cfg.time_limit = time_limit_reg;

    // a scan beat moves when the event queue has room
    assign in_take = push && !full;

    // configuration registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ms_reg    <= TICK_MS_RESET;
            time_limit_reg <= TIME_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_TICK_MS:    tick_ms_reg    <= cfg_data[TICK_W-1:0];
                CFG_TIME_LIMIT: time_limit_reg <= cfg_data[TIME_W-1:0];
                default:        ;
            endcase
        end
    end

    // key timers and classification
    fkp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_take),
        .key_code (key_code),
        .evt      (front_evt)
    );

    // decouples the key front from the settings back
    fkp_evq u_evq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_take),
        .wr_data (front_evt),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_evt),
        .empty   (q_empty)
    );

    // settings update and result queue
    fkp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .evt       (q_evt),
        .evt_empty (q_empty),
        .evt_pop   (q_pop),
        .res       (res),
        .res_empty (empty),
        .res_pop   (pop)
    );

    assign run_state        = res.run_state;
    assign menu_option      = res.menu_option;
    assign level_setting    = res.level_setting;
    assign time_setting     = res.time_setting;
    assign reload_remaining = res.reload_remaining;
    assign beep_short       = res.beep_short;
    assign beep_double      = res.beep_double;
    assign settings_done    = res.settings_done;
    assign blink_start      = res.blink_start;
    assign hold_active      = res.hold_active;

    // a confirmed setting always leaves the menu closed
    a_done_closes_menu: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && settings_done) |-> (menu_option == OPT_NONE))
        else $error("settings_done with menu still open");

    // a reload only happens when running stops
    a_reload_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && reload_remaining) |-> !run_state)
        else $error("reload_remaining while still running");

    // every blink comes with a beep of some kind
    a_blink_beeps: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && blink_start) |-> (beep_short || beep_double))
        else $error("blink_start without a beep");

    // the back never consumes an event it has not been given
    a_pop_needs_event: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("event queue popped while empty");

endmodule

`default_nettype wire

// ===== sv/fkp_front.sv =====
// fkp_front: key hold timers and click / repeat / long-hold classification
// depends on fkp_pkg
`default_nettype none

module fkp_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire fkp_pkg::fkp_cfg_t              cfg,
    input  wire logic                           in_valid,
    input  wire logic [2:0]                     key_code,
    output fkp_pkg::fkp_evt_t                   evt
);
    import fkp_pkg::*;

    localparam int SUM_W = COUNT_WIDTH + 1;

    localparam logic [2:0] KEY_START = 3'd1;
    localparam logic [2:0] KEY_MINUS = 3'd2;
    localparam logic [2:0] KEY_PLUS  = 3'd3;
    localparam logic [2:0] KEY_MENU  = 3'd4;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX        = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CLICK_MIN_MS   = COUNT_WIDTH'(100);
    localparam logic [COUNT_WIDTH-1:0] CLICK_MAX_MS   = COUNT_WIDTH'(1500);
    localparam logic [COUNT_WIDTH-1:0] LONG_MAX_MS    = COUNT_WIDTH'(3000);
    localparam logic [COUNT_WIDTH-1:0] ADJ_MAX_MS     = COUNT_WIDTH'(1400);
    localparam logic [COUNT_WIDTH-1:0] REPEAT_LO_MS   = COUNT_WIDTH'(1900);
    localparam logic [COUNT_WIDTH-1:0] REPEAT_HI_MS   = COUNT_WIDTH'(2100);
    localparam logic [COUNT_WIDTH-1:0] REPEAT_BASE_MS = COUNT_WIDTH'(1400);

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] cnt;
        logic                   pressed;
        logic                   long_hold;
        logic                   act;
        logic                   beep_d;
    } click_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] cnt;
        logic                   pressed;
        logic                   act;
        logic                   big;
    } rpt_t;

    logic [COUNT_WIDTH-1:0] press_reg [4];
    logic [COUNT_WIDTH-1:0] press_next [4];
    logic [3:0]             pressed_reg, pressed_next;
    logic [1:0]             long_reg, long_next;

    click_t start_res, menu_res;
    rpt_t   minus_res, plus_res;

    function automatic logic [COUNT_WIDTH-1:0] sat_add(
        input logic [COUNT_WIDTH-1:0] c,
        input logic [TICK_W-1:0]      t
    );
        logic [SUM_W-1:0] s;
        s = {1'b0, c} + SUM_W'(t);
        return s[SUM_W-1] ? CNT_MAX : s[COUNT_WIDTH-1:0];
    endfunction

    function automatic click_t click_step(
        input logic                   hit,
        input logic [COUNT_WIDTH-1:0] cnt,
        input logic                   pressed,
        input logic                   long_hold,
        input logic [TICK_W-1:0]      t
    );
        click_t r;
        r = '{cnt: cnt, pressed: pressed, long_hold: long_hold, act: 1'b0, beep_d: 1'b0};
        if (hit && !r.long_hold)
        begin
            r.cnt     = sat_add(r.cnt, t);
            r.pressed = 1'b1;
        end
        if (r.pressed)
        begin
            if (!hit)
            begin
                if (r.cnt > CLICK_MIN_MS && r.cnt < CLICK_MAX_MS)
                    r.act = 1'b1;
                r.pressed   = 1'b0;
                r.long_hold = 1'b0;
                r.cnt       = '0;
            end
            if (r.cnt > CLICK_MAX_MS && r.cnt < LONG_MAX_MS && !r.long_hold)
            begin
                r.beep_d    = 1'b1;
                r.long_hold = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic rpt_t repeat_step(
        input logic                   hit,
        input logic [COUNT_WIDTH-1:0] cnt,
        input logic                   pressed,
        input logic [TICK_W-1:0]      t
    );
        rpt_t r;
        r = '{cnt: cnt, pressed: pressed, act: 1'b0, big: 1'b0};
        if (hit)
        begin
            r.cnt     = sat_add(r.cnt, t);
            r.pressed = 1'b1;
        end
        if (r.pressed)
        begin
            if (!hit)
            begin
                if (r.cnt < ADJ_MAX_MS)
                    r.act = 1'b1;
                r.pressed = 1'b0;
                r.cnt     = '0;
            end
            if (r.cnt > REPEAT_LO_MS && r.cnt < REPEAT_HI_MS)
            begin
                r.act     = 1'b1;
                r.big     = 1'b1;
                r.pressed = 1'b0;
                r.cnt     = REPEAT_BASE_MS;
            end
        end
        return r;
    endfunction

    always_comb
    begin
        start_res = click_step(key_code == KEY_START, press_reg[0], pressed_reg[0],
                               long_reg[0], cfg.tick_ms);
        minus_res = repeat_step(key_code == KEY_MINUS, press_reg[1], pressed_reg[1],
                                cfg.tick_ms);
        plus_res  = repeat_step(key_code == KEY_PLUS, press_reg[2], pressed_reg[2],
                                cfg.tick_ms);
        menu_res  = click_step(key_code == KEY_MENU, press_reg[3], pressed_reg[3],
                               long_reg[1], cfg.tick_ms);

        press_next[0] = start_res.cnt;
        press_next[1] = minus_res.cnt;
        press_next[2] = plus_res.cnt;
        press_next[3] = menu_res.cnt;
        pressed_next  = {menu_res.pressed, plus_res.pressed,
                         minus_res.pressed, start_res.pressed};
        long_next     = {menu_res.long_hold, start_res.long_hold};

        evt.start_click = start_res.act;
        evt.menu_click  = menu_res.act;
        evt.minus_act   = minus_res.act;
        evt.minus_big   = minus_res.big;
        evt.plus_act    = plus_res.act;
        evt.plus_big    = plus_res.big;
        evt.long_beep   = start_res.beep_d | menu_res.beep_d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                press_reg[i] <= '0;
            pressed_reg <= '0;
            long_reg    <= '0;
        end
        else if (in_valid)
        begin
            for (int i = 0; i < 4; i++)
                press_reg[i] <= press_next[i];
            pressed_reg <= pressed_next;
            long_reg    <= long_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/fkp_evq.sv =====
// fkp_evq: small fifo of classified key beats between front and back
// depends on fkp_pkg
`default_nettype none

module fkp_evq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire fkp_pkg::fkp_evt_t wr_data,
    output logic                   full,
    input  wire logic              rd_en,
    output fkp_pkg::fkp_evt_t      rd_data,
    output logic                   empty
);
    import fkp_pkg::*;

    localparam int PTR_W = (EVQ_DEPTH > 1) ? $clog2(EVQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(EVQ_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(EVQ_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(EVQ_DEPTH - 1);

    fkp_evt_t          mem_reg [EVQ_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr, do_rd;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== sv/fkp_back.sv =====
// fkp_back: settings state, applies key beats and queues the result beats
// depends on fkp_pkg
`default_nettype none

module fkp_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fkp_pkg::fkp_cfg_t cfg,
    input  wire fkp_pkg::fkp_evt_t evt,
    input  wire logic              evt_empty,
    output logic                   evt_pop,
    output fkp_pkg::fkp_res_t      res,
    output logic                   res_empty,
    input  wire logic              res_pop
);
    import fkp_pkg::*;

    localparam logic [HOLD_W-1:0] HOLD_RELOAD_MS = HOLD_W'(1000);
    localparam int                DIFF_W         = TIME_W + 2;
    localparam logic [TIME_W-1:0] STEP_SMALL_S   = TIME_W'(60);
    localparam logic [TIME_W-1:0] STEP_BIG_S     = TIME_W'(600);
    localparam logic [TIME_W-1:0] TIME_FLOOR_S   = TIME_W'(60);

    typedef struct packed {
        logic              level;
        logic [TIME_W-1:0] time_s;
        logic              hold_load;
        logic              blink;
        logic              beep_s;
        logic              beep_d;
    } adj_t;

    logic              run_reg, run_next;
    logic [OPT_W-1:0]  option_reg, option_next;
    logic              level_reg, level_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    fkp_res_t          res_next;
    adj_t              adj_minus, adj_plus;

    // two-entry result queue
    fkp_res_t          rq_reg [2];
    logic              rq_wr_reg, rq_rd_reg;
    logic [1:0]        rq_cnt_reg;
    logic              rq_space, do_res_pop;

    function automatic adj_t adjust(
        input logic              up,
        input logic              big,
        input logic [OPT_W-1:0]  opt,
        input logic              level,
        input logic [TIME_W-1:0] time_s,
        input logic [TIME_W-1:0] time_limit
    );
        adj_t              a;
        logic [TIME_W-1:0] step;
        logic [DIFF_W-1:0] t;
        a = '{level: level, time_s: time_s, hold_load: 1'b0,
              blink: 1'b0, beep_s: 1'b0, beep_d: 1'b0};
        step = big ? STEP_BIG_S : STEP_SMALL_S;
        t    = '0;
        if (opt == OPT_LEVEL)
        begin
            if (level == up)
                a.beep_d = 1'b1;
            else
                a.beep_s = 1'b1;
            a.level     = up;
            a.hold_load = 1'b1;
            a.blink     = 1'b1;
        end
        else if (opt == OPT_TIME)
        begin
            if (up)
            begin
                t = {2'b00, time_s} + {2'b00, step};
                if (t > {2'b00, time_limit})
                    a.time_s = time_limit;
                else
                    a.time_s = t[TIME_W-1:0];
            end
            else
            begin
                t = {2'b00, time_s} - {2'b00, step};
                if ($signed(t) < $signed({2'b00, TIME_FLOOR_S}))
                    a.time_s = '0;
                else
                    a.time_s = t[TIME_W-1:0];
            end
            a.hold_load = 1'b1;
            a.blink     = 1'b1;
            a.beep_s    = 1'b1;
        end
        else
        begin
            a.beep_d = 1'b1;
        end
        return a;
    endfunction

    assign rq_space   = (rq_cnt_reg != 2'd2);
    assign evt_pop    = !evt_empty && rq_space;
    assign res_empty  = (rq_cnt_reg == 2'd0);
    assign do_res_pop = res_pop && !res_empty;
    assign res        = rq_reg[rq_rd_reg];

    always_comb
    begin
        run_next    = run_reg;
        option_next = option_reg;
        level_next  = level_reg;
        time_next   = time_reg;
        hold_next   = hold_reg;
        res_next    = '0;

        // no-blink hold counts down first, saturating at zero
        if (hold_reg != '0)
            hold_next = (hold_reg > HOLD_W'(cfg.tick_ms)) ?
                        hold_reg - HOLD_W'(cfg.tick_ms) : '0;

        if (evt.start_click)
        begin
            option_next           = OPT_NONE;
            res_next.settings_done = 1'b1;
            res_next.beep_short   = 1'b1;
            if (run_reg)
                res_next.reload_remaining = 1'b1;
            run_next = !run_reg;
        end

        adj_minus = adjust(1'b0, evt.minus_big, option_next, level_next, time_next,
                           cfg.time_limit);
        if (evt.minus_act)
        begin
            level_next = adj_minus.level;
            time_next  = adj_minus.time_s;
            if (adj_minus.hold_load)
                hold_next = HOLD_RELOAD_MS;
            res_next.blink_start = res_next.blink_start | adj_minus.blink;
            res_next.beep_short  = res_next.beep_short  | adj_minus.beep_s;
            res_next.beep_double = res_next.beep_double | adj_minus.beep_d;
        end

        adj_plus = adjust(1'b1, evt.plus_big, option_next, level_next, time_next,
                          cfg.time_limit);
        if (evt.plus_act)
        begin
            level_next = adj_plus.level;
            time_next  = adj_plus.time_s;
            if (adj_plus.hold_load)
                hold_next = HOLD_RELOAD_MS;
            res_next.blink_start = res_next.blink_start | adj_plus.blink;
            res_next.beep_short  = res_next.beep_short  | adj_plus.beep_s;
            res_next.beep_double = res_next.beep_double | adj_plus.beep_d;
        end

        if (evt.menu_click)
        begin
            option_next = option_next + OPT_W'(1);
            if (option_next == OPT_WRAP)
            begin
                option_next            = OPT_NONE;
                res_next.settings_done = 1'b1;
            end
            res_next.blink_start = 1'b1;
            res_next.beep_short  = 1'b1;
        end

        if (evt.long_beep)
            res_next.beep_double = 1'b1;

        res_next.run_state     = run_next;
        res_next.menu_option   = option_next;
        res_next.level_setting = level_next;
        res_next.time_setting  = time_next;
        res_next.hold_active   = (hold_next != '0);
    end

    always_ff @(posedge clk)
    begin
        if (evt_pop)
            rq_reg[rq_wr_reg] <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            option_reg <= OPT_NONE;
            level_reg  <= 1'b0;
            time_reg   <= '0;
            hold_reg   <= '0;
            rq_wr_reg  <= 1'b0;
            rq_rd_reg  <= 1'b0;
            rq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (evt_pop)
            begin
                run_reg    <= run_next;
                option_reg <= option_next;
                level_reg  <= level_next;
                time_reg   <= time_next;
                hold_reg   <= hold_next;
                rq_wr_reg  <= !rq_wr_reg;
            end
            if (do_res_pop)
                rq_rd_reg <= !rq_rd_reg;
            if (evt_pop && !do_res_pop)
                rq_cnt_reg <= rq_cnt_reg + 2'd1;
            else if (do_res_pop && !evt_pop)
                rq_cnt_reg <= rq_cnt_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire
